// ----- sv/fnms_pkg.sv -----
package fnms_pkg;

   // cell and result payload widths
   localparam int VALUE_W = 32;
   localparam int TILE_W  = 7;

   // register reset value and default tile capacity
   localparam logic [TILE_W-1:0] TILE_SIZE_RESET  = 7'd64;
   localparam int                MAX_TILE_DEFAULT = 64;

   // neighbour sum and count widths
   localparam int SUM_W   = VALUE_W + 2;
   localparam int COUNT_W = 3;

   // divide by three: the sum is split into a high and a low part, each part
   // is divided through a reciprocal multiply, and the high remainder is carried down
   localparam int                 SPLIT_W    = 17;
   localparam int                 HI_W       = SUM_W - SPLIT_W;
   localparam int                 QH_W       = HI_W - 1;
   localparam int                 T_W        = SPLIT_W + 2;
   localparam int                 QL_W       = T_W - 1;
   localparam int                 RECIP_W    = 20;
   localparam int                 DIV3_SHIFT = 21;
   localparam logic [RECIP_W-1:0] DIV3_RECIP = 20'd699051;
   localparam int                 HI_PROD_W  = HI_W + RECIP_W;
   localparam int                 LO_PROD_W  = T_W + RECIP_W;
   localparam int                 Q3_W       = QH_W + SPLIT_W;

   // one stored cell
   typedef struct packed {
      logic               present;
      logic [VALUE_W-1:0] value;
   } cell_type;

endpackage

// ----- sv/four_neighbour_mean_stencil_core.sv -----
// Four-neighbour mean over a padded square tile streamed in raster order.
// The req channel takes one padded cell per transaction (value and present
// flag). The tile is (N+2) by (N+2) cells, with N set by the csr port. A csr
// write restarts the tile. The rsp channel gives one transaction for each
// interior cell, in raster order. It carries the truncated mean of the present
// up, down, left and right neighbours, a flag when none is present, and a
// flag on the final interior cell of the tile.
// Throughput is one cell per cycle. The line store takes one write and two
// reads on every accepted cell, and the divide-by-three path is a pipeline
// of two multiply stages. A result passes through the stage 1 to stage 4
// registers into the output register after its down neighbour is accepted.
// When the receiver stalls, the whole pipeline holds. req_ready stays low
// while the output register holds a transaction that has not been taken.
// Reset clears the row and column counters and sets the tile size to 64,
// clamped to MAX_TILE. The line store is not cleared. Each entry is written
// within the current tile before it is read, so no clearing pass is run.
module four_neighbour_mean_stencil_core #(
   parameter int MAX_TILE = fnms_pkg::MAX_TILE_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fnms_pkg::VALUE_W-1:0] req_cell_value,
   input  logic                         req_cell_present,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fnms_pkg::VALUE_W-1:0] rsp_mean_value,
   output logic                         rsp_no_neighbour,
   output logic                         rsp_last_cell,
   input  logic                         csr_write_en,
   input  logic [fnms_pkg::TILE_W-1:0]  csr_write_data
);

   localparam int LINE_LEN = MAX_TILE + 2;
   localparam int DEPTH    = 2 * LINE_LEN;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(MAX_TILE + 2);

   localparam int VW  = fnms_pkg::VALUE_W;
   localparam int SW  = fnms_pkg::SUM_W;
   localparam int NW  = fnms_pkg::COUNT_W;
   localparam int SPW = fnms_pkg::SPLIT_W;
   localparam int CHK_W = SW + 2;

   // clamp a written tile size to 1..MAX_TILE
   function automatic logic [CW-1:0] clamp_size(input logic [fnms_pkg::TILE_W-1:0] v);
      logic [CW-1:0] n;
      if (v == '0) begin
         n = CW'(1);
      end else if (32'(v) > 32'(MAX_TILE)) begin
         n = CW'(MAX_TILE);
      end else begin
         n = CW'(v);
      end
      return n;
   endfunction

   // line store address: bank picks the row parity
   function automatic logic [AW-1:0] line_addr(input logic bank, input logic [CW-1:0] col);
      logic [AW-1:0] a;
      if (bank) begin
         a = AW'(LINE_LEN) + AW'(col);
      end else begin
         a = AW'(col);
      end
      return a;
   endfunction

   // contribution of one neighbour to the sum
   function automatic logic [SW-1:0] term(input fnms_pkg::cell_type c);
      logic [SW-1:0] t;
      if (c.present) begin
         t = SW'(c.value);
      end else begin
         t = '0;
      end
      return t;
   endfunction

   // output register
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_mean_ff;
   logic          rsp_none_ff;
   logic          rsp_last_ff;

   // pipeline advance: output register free or being taken
   logic advance;
   logic in_fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign in_fire   = req_valid && advance;

   // tile size and position counters
   logic [CW-1:0] active_n_ff;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] n_plus_one;
   logic          row_end;
   logic          produce;
   logic          last_here;

   assign n_plus_one = active_n_ff + CW'(1);
   assign row_end    = (col_ff == n_plus_one);
   assign produce    = (row_ff >= CW'(2)) && (col_ff >= CW'(1)) && (col_ff <= active_n_ff);
   assign last_here  = (row_ff == n_plus_one) && (col_ff == active_n_ff);

   // next position in raster order
   always_comb begin
      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         if (row_ff == n_plus_one) begin
            row_in = '0;
         end else begin
            row_in = row_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_n_ff <= clamp_size(fnms_pkg::TILE_SIZE_RESET);
         row_ff      <= '0;
         col_ff      <= '0;
      end else if (csr_write_en) begin
         active_n_ff <= clamp_size(csr_write_data);
         row_ff      <= '0;
         col_ff      <= '0;
      end else if (in_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line store addresses: up from the same parity bank, right from the other;
   // on the last column the right port fetches column 0 of this row for the next row
   fnms_pkg::cell_type cur_cell;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      up_addr;
   logic [AW-1:0]      right_addr;

   assign cur_cell.present = req_cell_present;
   assign cur_cell.value   = req_cell_value;
   assign wr_addr          = line_addr(row_ff[0], col_ff);
   assign up_addr          = wr_addr;
   assign right_addr       = row_end ? line_addr(row_ff[0], '0)
                                     : line_addr(!row_ff[0], col_ff + CW'(1));

   // line store: one write, two registered reads
   fnms_pkg::cell_type line_mem [DEPTH];
   fnms_pkg::cell_type up_rd_ff;
   fnms_pkg::cell_type right_rd_ff;
   fnms_pkg::cell_type mid_tap_ff;
   fnms_pkg::cell_type left_tap_ff;

   always_ff @(posedge clock) begin
      if (in_fire) begin
         line_mem[wr_addr] <= cur_cell;
         up_rd_ff          <= line_mem[up_addr];
         right_rd_ff       <= line_mem[right_addr];
         mid_tap_ff        <= right_rd_ff;
         left_tap_ff       <= mid_tap_ff;
      end
   end

   // stage 1: down cell and flags alongside the reads
   logic               s1_valid_ff;
   logic               s1_last_ff;
   fnms_pkg::cell_type s1_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_fire && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         s1_cur_ff  <= cur_cell;
         s1_last_ff <= last_here;
      end
   end

   // stage 1 sum and count of present neighbours
   logic [SW-1:0] sum_in;
   logic [NW-1:0] count_in;

   assign sum_in = term(s1_cur_ff) + term(up_rd_ff) + term(left_tap_ff) + term(right_rd_ff);
   assign count_in = NW'(s1_cur_ff.present) + NW'(up_rd_ff.present)
                   + NW'(left_tap_ff.present) + NW'(right_rd_ff.present);

   // stage 2 registers
   logic          s2_valid_ff;
   logic          s2_last_ff;
   logic [SW-1:0] s2_sum_ff;
   logic [NW-1:0] s2_count_ff;

   // stage 2: high part divided by three
   logic [fnms_pkg::HI_PROD_W-1:0] hi_prod;

   assign hi_prod = fnms_pkg::HI_PROD_W'(s2_sum_ff[SW-1:SPW])
                  * fnms_pkg::HI_PROD_W'(fnms_pkg::DIV3_RECIP);

   // stage 3 registers
   logic                      s3_valid_ff;
   logic                      s3_last_ff;
   logic [SW-1:0]             s3_sum_ff;
   logic [NW-1:0]             s3_count_ff;
   logic [fnms_pkg::QH_W-1:0] s3_qh_ff;

   // stage 3: remainder of the high part carried into the low part
   logic [fnms_pkg::HI_W-1:0]      hi_rem;
   logic [fnms_pkg::T_W-1:0]       lo_part;
   logic [fnms_pkg::LO_PROD_W-1:0] lo_prod;

   assign hi_rem  = s3_sum_ff[SW-1:SPW] - {s3_qh_ff, 1'b0} - fnms_pkg::HI_W'(s3_qh_ff);
   assign lo_part = {hi_rem[1:0], s3_sum_ff[SPW-1:0]};
   assign lo_prod = fnms_pkg::LO_PROD_W'(lo_part) * fnms_pkg::LO_PROD_W'(fnms_pkg::DIV3_RECIP);

   // stage 4 registers
   logic                      s4_valid_ff;
   logic                      s4_last_ff;
   logic [SW-1:0]             s4_sum_ff;
   logic [NW-1:0]             s4_count_ff;
   logic [fnms_pkg::QH_W-1:0] s4_qh_ff;
   logic [fnms_pkg::QL_W-1:0] s4_ql_ff;

   logic [fnms_pkg::QH_W-1:0] s4_qh_in;
   assign s4_qh_in = s3_qh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff  <= s1_last_ff;
         s2_sum_ff   <= sum_in;
         s2_count_ff <= count_in;
         s3_last_ff  <= s2_last_ff;
         s3_sum_ff   <= s2_sum_ff;
         s3_count_ff <= s2_count_ff;
         s3_qh_ff    <= hi_prod[fnms_pkg::HI_PROD_W-1:fnms_pkg::DIV3_SHIFT];
         s4_last_ff  <= s3_last_ff;
         s4_sum_ff   <= s3_sum_ff;
         s4_count_ff <= s3_count_ff;
         s4_qh_ff    <= s4_qh_in;
         s4_ql_ff    <= lo_prod[fnms_pkg::LO_PROD_W-1:fnms_pkg::DIV3_SHIFT];
      end
   end

   // stage 4: pick the quotient for the neighbour count
   logic [fnms_pkg::Q3_W-1:0] q3;
   logic [VW-1:0]             mean_in;
   logic                      none_in;

   assign q3 = {s4_qh_ff, {SPW{1'b0}}} + fnms_pkg::Q3_W'(s4_ql_ff);

   always_comb begin
      mean_in = '0;
      none_in = 1'b0;
      unique case (s4_count_ff)
         3'd0: none_in = 1'b1;
         3'd1: mean_in = s4_sum_ff[VW-1:0];
         3'd2: mean_in = s4_sum_ff[VW:1];
         3'd3: mean_in = q3[VW-1:0];
         3'd4: mean_in = s4_sum_ff[VW+1:2];
         default: mean_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mean_ff <= mean_in;
         rsp_none_ff <= none_in;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_no_neighbour = rsp_none_ff;
   assign rsp_last_cell    = rsp_last_ff;

   // checks
   logic [CHK_W-1:0] q3_times3;
   assign q3_times3 = CHK_W'(q3) * CHK_W'(3);

   // counters stay inside the padded tile
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= n_plus_one && col_ff <= n_plus_one)
      else $error("position counter beyond padded tile");

   // the last padded cell wraps both counters
   a_tile_wrap: assert property (@(posedge clock) disable iff (reset)
      in_fire && row_end && row_ff == n_plus_one |=> row_ff == '0 && col_ff == '0)
      else $error("tile did not wrap after final cell");

   // a pipeline step without a new cell leaves stage 1 empty
   a_stage1_source: assert property (@(posedge clock) disable iff (reset)
      advance && !in_fire |=> !s1_valid_ff)
      else $error("stage 1 filled without an accepted transaction");

   // the divide by three path gives the truncated quotient
   a_div3: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && s4_count_ff == 3'd3 |->
         q3_times3 <= CHK_W'(s4_sum_ff) && CHK_W'(s4_sum_ff) - q3_times3 < CHK_W'(3))
      else $error("divide by three out of range");

   // an empty neighbourhood gives a zero mean
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_neighbour |-> rsp_mean_value == '0)
      else $error("non-zero mean without neighbours");

endmodule

// ----- bench/tb.sv -----
module tb;

   localparam int          LINE_LEN      = fnms_pkg::MAX_TILE_DEFAULT + 2;
   localparam int          DRAIN_CYCLES  = 16;
   localparam int          RANDOM_ITEMS  = 1400;
   localparam int unsigned CYCLE_LIMIT   = 600000;

   // receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PERIODIC
   } stall_mode_type;

   // one expected stencil output
   typedef struct packed {
      logic [fnms_pkg::VALUE_W-1:0] mean_value;
      logic                         no_neighbour;
      logic                         last_cell;
   } mean_result_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [fnms_pkg::VALUE_W-1:0]   req_cell_value   = '0;
   logic                           req_cell_present = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic [fnms_pkg::VALUE_W-1:0]   rsp_mean_value;
   logic                           rsp_no_neighbour;
   logic                           rsp_last_cell;
   logic                           csr_write_en     = 1'b0;
   logic [fnms_pkg::TILE_W-1:0]    csr_write_data   = '0;

   // predictor state
   logic [fnms_pkg::TILE_W-1:0]    tile_reg = fnms_pkg::TILE_SIZE_RESET;
   fnms_pkg::cell_type             line_cells [0:2*LINE_LEN-1];
   int unsigned                    row_pos = 0;
   int unsigned                    col_pos = 0;
   mean_result_type                expected_means [$];

   int unsigned          failures     = 0;
   int unsigned          cycle_count  = 0;
   int unsigned          burst_left   = 0;
   bit                   offering     = 1'b0;

   // long receiver hold requests
   int unsigned          stall_len        = 0;
   int unsigned          stall_req_count  = 0;
   int unsigned          stall_seen_count = 0;
   int unsigned          hold_left        = 0;
   stall_mode_type       stall_mode       = READY_ALWAYS;
   int unsigned          mode_left        = 0;
   int unsigned          period_pos       = 0;

   four_neighbour_mean_stencil_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_value   (req_cell_value),
      .req_cell_present (req_cell_present),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_no_neighbour (rsp_no_neighbour),
      .rsp_last_cell    (rsp_last_cell),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < 2*LINE_LEN; i++) line_cells[i] = '0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // tile size in use after clamping
   function automatic int unsigned tile_in_use();
      int unsigned n;
      n = 32'(tile_reg);
      if (n == 0) n = 1;
      if (n > fnms_pkg::MAX_TILE_DEFAULT) n = fnms_pkg::MAX_TILE_DEFAULT;
      return n;
   endfunction

   // expected mean for an accepted cell, then line store and position update
   task automatic predict_mean(input fnms_pkg::cell_type cur);
      int unsigned                  n;
      logic [fnms_pkg::SUM_W-1:0]   sum;
      logic [fnms_pkg::SUM_W-1:0]   count;
      logic [fnms_pkg::SUM_W-1:0]   quotient;
      fnms_pkg::cell_type           around [4];
      mean_result_type              res;
      n = tile_in_use();
      if (row_pos >= 2 && col_pos >= 1 && col_pos <= n) begin
         around[0] = cur;
         around[1] = line_cells[(row_pos & 1) * LINE_LEN + col_pos];
         around[2] = line_cells[((row_pos - 1) & 1) * LINE_LEN + col_pos - 1];
         around[3] = line_cells[((row_pos - 1) & 1) * LINE_LEN + col_pos + 1];
         sum   = '0;
         count = '0;
         foreach (around[k]) begin
            if (around[k].present) begin
               sum   = sum + around[k].value;
               count = count + 1;
            end
         end
         if (count == 0) begin
            res.mean_value   = '0;
            res.no_neighbour = 1'b1;
         end else begin
            quotient         = sum / count;
            res.mean_value   = quotient[fnms_pkg::VALUE_W-1:0];
            res.no_neighbour = 1'b0;
         end
         res.last_cell = (row_pos == n + 1 && col_pos == n);
         expected_means.push_back(res);
      end
      line_cells[(row_pos & 1) * LINE_LEN + col_pos] = cur;
      col_pos++;
      if (col_pos >= n + 2) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= n + 2) row_pos = 0;
      end
   endtask

   // random cell, values biased towards the extremes
   function automatic fnms_pkg::cell_type random_cell(input int unsigned present_pct);
      fnms_pkg::cell_type c;
      case ($urandom_range(0, 9))
         0:       c.value = '0;
         1:       c.value = '1;
         2:       c.value = $urandom_range(0, 15);
         3:       c.value = 32'hFFFF_0000 | $urandom;
         default: c.value = $urandom;
      endcase
      c.present = ($urandom_range(0, 99) < present_pct);
      return c;
   endfunction

   task automatic drop_valid();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // offer one cell and wait for its transaction
   task automatic send_cell(input fnms_pkg::cell_type c);
      req_valid        <= 1'b1;
      req_cell_value   <= c.value;
      req_cell_present <= c.present;
      offering = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_mean(c);
   endtask

   // sender in bursts with random gaps
   task automatic paced_send(input fnms_pkg::cell_type c);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_cell(c);
   endtask

   // wait until every expected mean has come and the pipeline is empty
   task automatic wait_drained();
      drop_valid();
      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tile_size(input logic [fnms_pkg::TILE_W-1:0] size);
      csr_write_data <= size;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      tile_reg = size;
      row_pos  = 0;
      col_pos  = 0;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // one 3 by 3 padded tile around a single interior cell
   task automatic send_plus(input fnms_pkg::cell_type up, input fnms_pkg::cell_type left,
                            input fnms_pkg::cell_type right, input fnms_pkg::cell_type down);
      for (int i = 0; i < 9; i++) begin
         case (i)
            1:       send_cell(up);
            3:       send_cell(left);
            5:       send_cell(right);
            7:       send_cell(down);
            default: send_cell(random_cell(50));
         endcase
      end
   endtask

   // extremes of the sum and the count on a single interior cell
   task automatic test_single_cell_tiles();
      fnms_pkg::cell_type full_on;
      fnms_pkg::cell_type full_off;
      full_on  = '{present: 1'b1, value: '1};
      full_off = '{present: 1'b0, value: '1};
      write_tile_size(7'd1);
      send_plus(full_on, full_on, full_on, full_on);
      send_plus(full_on, full_on, full_on, full_off);
      wait_drained();
      // zero size acts as one
      write_tile_size(7'd0);
      send_plus(full_off, full_off, full_off, full_off);
      wait_drained();
   endtask

   // sender stops mid tile until everything is out, then goes on
   task automatic test_drain_mid_tile();
      write_tile_size(7'd6);
      repeat (30) paced_send(random_cell(80));
      wait_drained();
      repeat (34) paced_send(random_cell(80));
      wait_drained();
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_receiver_backpressure();
      write_tile_size(7'd8);
      stall_len = 400;
      stall_req_count++;
      repeat (300) send_cell(random_cell(90));
      wait_drained();
   endtask

   // tiles of random sizes, mostly whole, some cut short by a size write
   task automatic test_random_tiles();
      int unsigned                 sent;
      int unsigned                 n;
      int unsigned                 cells;
      int unsigned                 total;
      int unsigned                 pct;
      logic [fnms_pkg::TILE_W-1:0] size;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 11))
            0:       size = 7'd0;
            1:       size = 7'd127;
            2:       size = 7'd64;
            3:       size = 7'd1;
            4:       size = fnms_pkg::TILE_W'($urandom_range(13, 63));
            default: size = fnms_pkg::TILE_W'($urandom_range(2, 12));
         endcase
         write_tile_size(size);
         n     = tile_in_use();
         cells = (n + 2) * (n + 2);
         if (n > 12) begin
            total = (n + 2) * $urandom_range(2, 4) + $urandom_range(0, n + 1);
         end else begin
            total = cells * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) total += $urandom_range(1, cells - 1);
         end
         case ($urandom_range(0, 3))
            0:       pct = 100;
            1:       pct = 50;
            2:       pct = 10;
            default: pct = 85;
         endcase
         repeat (total) paced_send(random_cell(pct));
         sent += total;
         wait_drained();
      end
   endtask

   // receiver stall pattern and long hold
   always @(posedge clock) begin
      if (stall_req_count != stall_seen_count) begin
         stall_seen_count = stall_req_count;
         hold_left        = stall_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 400);
         end
         mode_left--;
         period_pos = (period_pos + 1) % 7;
         case (stall_mode)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM:   rsp_ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: rsp_ready <= (period_pos < 3);
         endcase
      end
   end

   // compare each result transaction with the oldest expected mean
   always @(posedge clock) begin
      mean_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            $display("%0t: unexpected result, expected none, got mean %h flag %b last %b",
                     $time, rsp_mean_value, rsp_no_neighbour, rsp_last_cell);
            failures++;
         end else begin
            want = expected_means.pop_front();
            if (rsp_mean_value !== want.mean_value) begin
               $display("%0t: mean_value expected %h got %h",
                        $time, want.mean_value, rsp_mean_value);
               failures++;
            end
            if (rsp_no_neighbour !== want.no_neighbour) begin
               $display("%0t: no_neighbour expected %b got %b",
                        $time, want.no_neighbour, rsp_no_neighbour);
               failures++;
            end
            if (rsp_last_cell !== want.last_cell) begin
               $display("%0t: last_cell expected %b got %b",
                        $time, want.last_cell, rsp_last_cell);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_cell_tiles();
      test_drain_mid_tile();
      test_receiver_backpressure();
      test_random_tiles();
      wait_drained();
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
